### rtl/mfcs_pkg.sv
// Package for the MLP forward/cost statistics unit.
// Constants, command codes and control structs; no dependencies.
package mfcs_pkg;
  localparam int HIDDEN_UNITS = 5;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int PARAM_DEPTH = 5 * HIDDEN_UNITS + 1;
  localparam int PAW = $clog2(PARAM_DEPTH);
  localparam int SAW = $clog2(SIGMOID_ENTRIES);
  localparam int SIG_SHIFT = 20 - SAW;

  localparam logic [2:0] CMD_LOAD_PARAM = 3'd0;
  localparam logic [2:0] CMD_LOAD_SIG   = 3'd1;
  localparam logic [2:0] CMD_EVAL       = 3'd2;
  localparam logic [2:0] CMD_FINISH     = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  localparam logic CFG_COST_LIMIT = 1'b0;
  localparam logic CFG_PASS_RATIO = 1'b1;

  typedef struct packed {
    logic        req;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  function automatic logic [SAW-1:0] sig_index(input logic signed [63:0] arg);
    logic signed [63:0] a;
    logic [63:0] p;
    a = arg;
    if (a < -64'sd524288) a = -64'sd524288;
    if (a > 64'sd524287) a = 64'sd524287;
    p = 64'(a + 64'sd524288) >> SIG_SHIFT;
    return p[SAW-1:0];
  endfunction
endpackage

### rtl/mfcs_divider.sv
// Restoring radix-2 divider, 64 by 32 bits, one quotient bit per cycle.
// Depends on mfcs_pkg.
module mfcs_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  mfcs_pkg::div_req_t req,
  output mfcs_pkg::div_rsp_t rsp
);
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sh;

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r[31:0], quo_r[63]};
    if (req.req) begin
      quo_nxt = req.dividend; rem_nxt = '0; dvs_nxt = req.divisor;
      cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 7'd0) else $error("divider busy with zero count");
  a_done_follow: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("done without work");
endmodule

### rtl/mlp_forward_cost_stats_unit.sv
// Top level of the MLP forward/cost statistics unit: sequencer, memories, stats.
// Depends on mfcs_pkg and mfcs_divider.
//
//  channel | dir | fields
//  in_     | in  | tdata: command, index, word, in_a, in_b, in_c, target
//  out_    | out | tdata: prediction, cost, within_limit, counts, extremes, mean, good
//  cfg_    | in  | we, index, data (cost_limit, pass_ratio_permille)
//
// Loads and clear take effect on acceptance. Evaluate steps through read, multiply and
// accumulate for each input weight and threshold of every hidden unit with a sigmoid
// read and write, then each output weight and the output threshold and lookup, then cost
// and stats. Finish runs the bit-serial divider (none with zero samples).
// No clearing pass after reset; both RAMs are undefined until loaded.
// in_tready is low while an item is in work or its result waits in the output register.
module mlp_forward_cost_stats_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0], index[10:3], word[42:11], in_a[74:43], in_b[106:75],
  // in_c[138:107], target[155:139], zero fill
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // prediction[15:0], cost[47:16], within_limit[48], sample_count[80:49],
  // passing_count[112:81], largest_cost[144:113], smallest_cost[176:145],
  // mean_cost[208:177], model_good[209], zero fill
  output logic [215:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int HU = mfcs_pkg::HIDDEN_UNITS;
  localparam int HW = $clog2(HU + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_SIGRD = 4'd4;
  localparam logic [3:0] S_SIGWR = 4'd5;
  localparam logic [3:0] S_COST  = 4'd6;
  localparam logic [3:0] S_STAT  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [31:0] cost_limit_r;
  logic [9:0]  ratio_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_limit_r <= 32'd4295; ratio_r <= 10'd900;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfcs_pkg::CFG_COST_LIMIT: cost_limit_r <= cfg_data;
        mfcs_pkg::CFG_PASS_RATIO: ratio_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [2:0]  cmd;
  logic [7:0]  idx;
  logic [31:0] wrd;
  assign cmd = in_tdata[2:0];
  assign idx = in_tdata[10:3];
  assign wrd = in_tdata[42:11];
  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // memories
  logic [31:0] pmem [mfcs_pkg::PARAM_DEPTH];
  logic [15:0] smem [mfcs_pkg::SIGMOID_ENTRIES];
  logic [15:0] hmem [HU];
  logic [mfcs_pkg::PAW-1:0] prd_addr;
  logic [mfcs_pkg::SAW-1:0] srd_addr;
  logic [31:0] prd_q;
  logic [15:0] srd_q;
  logic        pwe, swe;
  assign pwe = in_fire && cmd == mfcs_pkg::CMD_LOAD_PARAM &&
               {24'd0, idx} < 32'(mfcs_pkg::PARAM_DEPTH);
  assign swe = in_fire && cmd == mfcs_pkg::CMD_LOAD_SIG &&
               {24'd0, idx} < 32'(mfcs_pkg::SIGMOID_ENTRIES);
  always_ff @(posedge clk) begin
    if (pwe) pmem[idx[mfcs_pkg::PAW-1:0]] <= wrd;
    prd_q <= pmem[prd_addr];
  end
  always_ff @(posedge clk) begin
    if (swe) smem[idx[mfcs_pkg::SAW-1:0]] <= wrd[15:0];
    srd_q <= smem[srd_addr];
  end

  logic [3:0]  st_r, st_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [1:0]  i_r, i_nxt;
  logic        outl_r, outl_nxt;
  logic signed [31:0] xa_r, xb_r, xc_r;
  logic [16:0] tgt_r;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r;
  logic [15:0] pred_r, pred_nxt;
  logic [31:0] cost_r, cost_nxt;
  logic        pass_r, pass_nxt;
  logic [31:0] cnt_r, cnt_nxt, pcnt_r, pcnt_nxt, max_r, max_nxt, min_r, min_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [31:0] mean_r, mean_nxt;
  logic        good_r, good_nxt, fin_r, fin_nxt;
  logic [15:0] hid_q;

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_fire && cmd == mfcs_pkg::CMD_EVAL) begin
      xa_r <= in_tdata[74:43]; xb_r <= in_tdata[106:75];
      xc_r <= in_tdata[138:107]; tgt_r <= in_tdata[155:139];
    end
    if (st_r == S_SIGWR && !outl_r) hmem[h_r[HW-1:0]] <= srd_q;
    hid_q <= hmem[h_r[HW-1:0]];
  end

  // operand select and multiply
  logic signed [32:0] mop;
  always_comb begin
    if (outl_r) mop = $signed({17'd0, hid_q});
    else begin
      case (i_r)
        2'd0: mop = 33'(xa_r);
        2'd1: mop = 33'(xb_r);
        default: mop = 33'(xc_r);
      endcase
    end
  end
  always_ff @(posedge clk) prod_r <= 64'($signed(prd_q) * mop);

  mfcs_pkg::div_req_t dreq;
  mfcs_pkg::div_rsp_t drsp;
  mfcs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [17:0] dif;
  logic [35:0] sq;
  logic [64:0] sum_add;
  always_comb begin
    st_nxt = st_r; h_nxt = h_r; i_nxt = i_r; outl_nxt = outl_r; acc_nxt = acc_r;
    pred_nxt = pred_r; cost_nxt = cost_r; pass_nxt = pass_r;
    cnt_nxt = cnt_r; pcnt_nxt = pcnt_r; max_nxt = max_r; min_nxt = min_r;
    sum_nxt = sum_r; mean_nxt = mean_r; good_nxt = good_r; fin_nxt = fin_r;
    prd_addr = '0; srd_addr = mfcs_pkg::sig_index(acc_r);
    dreq = '0;
    dif = $signed({2'b0, pred_r}) - $signed({1'b0, tgt_r});
    sq = 36'(dif * dif) >> 1;
    sum_add = {1'b0, sum_r} + {33'd0, cost_r};
    if (outl_r) begin
      if (i_r == 2'd3) prd_addr = mfcs_pkg::PAW'(5 * HU);
      else prd_addr = mfcs_pkg::PAW'(3 * HU + 32'(h_r));
    end else begin
      if (i_r == 2'd3) prd_addr = mfcs_pkg::PAW'(4 * HU + 32'(h_r));
      else prd_addr = mfcs_pkg::PAW'(32'(i_r) * HU + 32'(h_r));
    end
    unique case (st_r)
      S_IDLE: if (in_fire) begin
        unique case (cmd)
          mfcs_pkg::CMD_EVAL: begin
            st_nxt = S_RD; h_nxt = '0; i_nxt = '0; outl_nxt = 1'b0;
            acc_nxt = '0; fin_nxt = 1'b0;
          end
          mfcs_pkg::CMD_FINISH: begin
            fin_nxt = 1'b1; mean_nxt = '0; good_nxt = 1'b0;
            if (cnt_r != 32'd0) begin
              dreq.req = 1'b1; dreq.dividend = sum_r; dreq.divisor = cnt_r;
              good_nxt = ({32'd0, pcnt_r} * 64'd1000) > ({54'd0, ratio_r} * {32'd0, cnt_r});
              st_nxt = S_DIV;
            end else st_nxt = S_OUT;
          end
          mfcs_pkg::CMD_CLEAR: begin
            cnt_nxt = '0; pcnt_nxt = '0; max_nxt = '0; min_nxt = '1; sum_nxt = '0;
          end
          default: ;
        endcase
      end
      S_RD: st_nxt = S_MUL;
      S_MUL: st_nxt = S_ACC;
      S_ACC: begin
        if (i_r == 2'd3) acc_nxt = acc_r - 64'($signed(prd_q));
        else acc_nxt = acc_r + (prod_r >>> 16);
        if (i_r == 2'd3) begin
          st_nxt = S_SIGRD;
        end else begin
          i_nxt = (outl_r && i_r == 2'd0 && h_r != HW'(HU - 1)) ? 2'd0 :
                  (outl_r && i_r == 2'd0) ? 2'd3 :
                  (!outl_r && i_r == 2'd2) ? 2'd3 : i_r + 2'd1;
          if (outl_r && i_r == 2'd0 && h_r != HW'(HU - 1)) h_nxt = h_r + HW'(1);
          st_nxt = S_RD;
        end
      end
      S_SIGRD: st_nxt = S_SIGWR;
      S_SIGWR: begin
        acc_nxt = '0; i_nxt = '0;
        if (outl_r) begin
          pred_nxt = srd_q; st_nxt = S_COST;
        end else if (h_r == HW'(HU - 1)) begin
          outl_nxt = 1'b1; h_nxt = '0; st_nxt = S_RD;
        end else begin
          h_nxt = h_r + HW'(1); st_nxt = S_RD;
        end
      end
      S_COST: begin
        cost_nxt = (sq[35:32] != 4'd0) ? 32'hFFFF_FFFF : sq[31:0];
        st_nxt = S_STAT;
      end
      S_STAT: begin
        pass_nxt = cost_r < cost_limit_r;
        if (cnt_r != 32'hFFFF_FFFF) cnt_nxt = cnt_r + 32'd1;
        if (cost_r < cost_limit_r && pcnt_r != 32'hFFFF_FFFF) pcnt_nxt = pcnt_r + 32'd1;
        if (cost_r > max_r) max_nxt = cost_r;
        if (cost_r < min_r) min_nxt = cost_r;
        sum_nxt = sum_add[64] ? '1 : sum_add[63:0];
        st_nxt = S_OUT;
      end
      S_DIV: if (drsp.done) begin
        mean_nxt = (drsp.quotient[63:32] != 32'd0) ? '1 : drsp.quotient[31:0];
        st_nxt = S_OUT;
      end
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; pred_r <= pred_nxt; cost_r <= cost_nxt; pass_r <= pass_nxt;
    mean_r <= mean_nxt; good_r <= good_nxt; i_r <= i_nxt; h_r <= h_nxt;
    outl_r <= outl_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; fin_r <= 1'b0;
      cnt_r <= '0; pcnt_r <= '0; max_r <= '0; min_r <= '1; sum_r <= '0;
    end else begin
      st_r <= st_nxt; fin_r <= fin_nxt;
      cnt_r <= cnt_nxt; pcnt_r <= pcnt_nxt; max_r <= max_nxt; min_r <= min_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {6'd0, fin_r ? good_r : 1'b0, fin_r ? mean_r : 32'd0,
                      min_r, max_r, pcnt_r, cnt_r,
                      fin_r ? 1'b0 : pass_r, fin_r ? 32'd0 : cost_r,
                      fin_r ? 16'd0 : pred_r};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  a_cnt_ge_pass: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= cnt_r) else $error("pass count above sample count");
  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> fin_r) else $error("divide outside finish");
endmodule

### test/tb_mlp_forward_cost_stats_unit.sv
// Testbench for mlp_forward_cost_stats_unit: random and directed command streams
// checked against an in-bench fixed-point network and statistics predictor.
// Depends on mfcs_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_mlp_forward_cost_stats_unit;
  typedef bit bool_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // command, index, word, in_a, in_b, in_c, target, zero fill
  logic [159:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // prediction, cost, within_limit, sample_count, passing_count, largest_cost,
  // smallest_cost, mean_cost, model_good, zero fill
  logic [215:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_data = '0;

  mlp_forward_cost_stats_unit dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [16:0]        target;
    logic signed [31:0] xc;
    logic signed [31:0] xb;
    logic signed [31:0] xa;
    logic signed [31:0] word;
    logic [7:0]         index;
    logic [2:0]         command;
  } cmd_item_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic        good;
    logic [31:0] mean;
    logic [31:0] cmin;
    logic [31:0] cmax;
    logic [31:0] passed;
    logic [31:0] count;
    logic        in_lim;
    logic [31:0] cost;
    logic [15:0] pred;
  } stats_rec_t;

  // predictor state
  logic signed [31:0] weights [mfcs_pkg::PARAM_DEPTH];
  logic [15:0]        sig_tab [mfcs_pkg::SIGMOID_ENTRIES];
  logic [31:0] lim_q, ratio_q;
  logic [31:0] n_eval, n_pass, c_max, c_min;
  logic [63:0] c_sum;

  cmd_item_t  pending_cmds[$];
  stats_rec_t expected_stats[$];
  int errors = 0, cycles = 0;
  bool_t quiet_in, quiet_out;

  function automatic logic signed [63:0] fl16(logic signed [63:0] v);
    return v >>> 16;
  endfunction

  function automatic logic [15:0] sig_of(logic signed [63:0] arg);
    logic signed [63:0] a;
    logic [63:0] p;
    a = arg;
    if (a < -64'sd524288) a = -64'sd524288;
    if (a > 64'sd524287) a = 64'sd524287;
    p = ((a + 64'sd524288) * mfcs_pkg::SIGMOID_ENTRIES) >> 20;
    return sig_tab[p[7:0]];
  endfunction

  task automatic clear_totals();
    n_eval = 0; n_pass = 0; c_max = 0; c_min = '1; c_sum = 0;
  endtask

  task automatic predict_stats(input cmd_item_t it);
    stats_rec_t r;
    logic signed [63:0] acc, xs [3], d;
    logic [15:0] hid [mfcs_pkg::HIDDEN_UNITS];
    logic [63:0] hs;
    r = '0;
    case (it.command)
      mfcs_pkg::CMD_LOAD_PARAM:
        if (it.index < mfcs_pkg::PARAM_DEPTH) weights[it.index] = it.word;
      mfcs_pkg::CMD_LOAD_SIG: sig_tab[it.index] = it.word[15:0];
      mfcs_pkg::CMD_CLEAR: clear_totals();
      mfcs_pkg::CMD_FINISH: begin
        r.count = n_eval; r.passed = n_pass; r.cmax = c_max; r.cmin = c_min;
        if (n_eval != 0) begin
          hs = c_sum / n_eval;
          r.mean = (hs > 64'hFFFF_FFFF) ? '1 : hs[31:0];
          r.good = (64'(n_pass) * 1000) > (64'(ratio_q) * n_eval);
        end
        expected_stats.push_back(r);
      end
      mfcs_pkg::CMD_EVAL: begin
        xs[0] = it.xa; xs[1] = it.xb; xs[2] = it.xc;
        for (int h = 0; h < mfcs_pkg::HIDDEN_UNITS; h++) begin
          acc = 0;
          for (int i = 0; i < 3; i++)
            acc += fl16(64'(weights[i*mfcs_pkg::HIDDEN_UNITS+h]) * xs[i]);
          acc -= weights[4*mfcs_pkg::HIDDEN_UNITS+h];
          hid[h] = sig_of(acc);
        end
        acc = 0;
        for (int h = 0; h < mfcs_pkg::HIDDEN_UNITS; h++)
          acc += fl16(64'(weights[3*mfcs_pkg::HIDDEN_UNITS+h]) * $signed({48'd0, hid[h]}));
        acc -= weights[5*mfcs_pkg::HIDDEN_UNITS];
        r.pred = sig_of(acc);
        d = $signed({48'd0, r.pred}) - $signed({47'd0, it.target});
        hs = 64'(d * d) >> 1;
        r.cost = (hs > 64'hFFFF_FFFF) ? '1 : hs[31:0];
        r.in_lim = r.cost < lim_q;
        if (n_eval != '1) n_eval++;
        if (r.in_lim && n_pass != '1) n_pass++;
        if (r.cost > c_max) c_max = r.cost;
        if (r.cost < c_min) c_min = r.cost;
        c_sum = (c_sum > ~64'd0 - r.cost) ? ~64'd0 : c_sum + r.cost;
        r.count = n_eval; r.passed = n_pass; r.cmax = c_max; r.cmin = c_min;
        expected_stats.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() > 0 && (quiet_in || $urandom_range(99) >= 8)) begin
          in_tdata <= {4'd0, pending_cmds[0]};
          predict_stats(pending_cmds.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= quiet_out || ($urandom_range(99) >= 8);
    end
  end

  // monitor
  always @(posedge clk) begin
    stats_rec_t got, want;
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_stats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer %h", out_tdata);
      end else begin
        want = expected_stats.pop_front();
        if (got[209:0] !== want[209:0]) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %h got %h", want, got);
        end
      end
    end
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic cmd_item_t mk(logic [2:0] c, logic [7:0] i, logic [31:0] w);
    cmd_item_t t;
    t = '0; t.command = c; t.index = i; t.word = w;
    return t;
  endfunction

  function automatic cmd_item_t mk_eval(logic [31:0] a, logic [31:0] b, logic [31:0] cc,
                                        logic [16:0] tg);
    cmd_item_t t;
    t = mk(mfcs_pkg::CMD_EVAL, 8'($urandom), $urandom);
    t.xa = a; t.xb = b; t.xc = cc; t.target = tg;
    return t;
  endfunction

  function automatic logic [31:0] rnd_small();
    return $urandom_range(1) ? $urandom : 32'($signed($urandom_range(262143)) - 131072);
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || in_tvalid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_cfg(logic idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mfcs_pkg::CFG_COST_LIMIT) lim_q = v; else ratio_q = 32'(v[9:0]);
  endtask

  task automatic load_params(bit wide);
    for (int i = 0; i < mfcs_pkg::PARAM_DEPTH; i++)
      pending_cmds.push_back(mk(mfcs_pkg::CMD_LOAD_PARAM, 8'(i),
                                wide ? $urandom : rnd_small()));
  endtask

  task automatic load_sig();
    for (int i = 0; i < mfcs_pkg::SIGMOID_ENTRIES; i++)
      pending_cmds.push_back(mk(mfcs_pkg::CMD_LOAD_SIG, 8'(i), $urandom));
  endtask

  initial begin
    int lims [4];
    int rats [4];
    cmd_item_t t;
    lim_q = 4295; ratio_q = 900; clear_totals();
    quiet_in = 0; quiet_out = 0;
    lims = '{0, 32'hFFFF_FFFF, 4295, 32'h2000_0000};
    rats = '{1000, 0, 500, 900};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed: finish before any sample, loads, extremes, ignored commands
    pending_cmds.push_back(mk(mfcs_pkg::CMD_FINISH, 8'd0, 32'd0));
    load_params(0);
    load_sig();
    pending_cmds.push_back(mk(mfcs_pkg::CMD_LOAD_PARAM, 8'(mfcs_pkg::PARAM_DEPTH), 32'h1234));
    pending_cmds.push_back(mk(mfcs_pkg::CMD_LOAD_PARAM, 8'hFF, 32'h5678));
    pending_cmds.push_back(mk_eval(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 17'd0));
    pending_cmds.push_back(mk_eval(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'd65536));
    pending_cmds.push_back(mk_eval(32'd0, 32'd0, 32'd0, 17'h1FFFF));
    pending_cmds.push_back(mk_eval(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 17'd32768));
    for (int c = 5; c < 8; c++) pending_cmds.push_back(mk(3'(c), 8'd0, 32'd0));
    pending_cmds.push_back(mk(mfcs_pkg::CMD_FINISH, 8'd0, 32'd0));
    pending_cmds.push_back(mk(mfcs_pkg::CMD_CLEAR, 8'd0, 32'd0));
    pending_cmds.push_back(mk(mfcs_pkg::CMD_FINISH, 8'd0, 32'd0));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_cfg(mfcs_pkg::CFG_COST_LIMIT, lims[ph]);
      set_cfg(mfcs_pkg::CFG_PASS_RATIO, rats[ph]);
      quiet_in = (ph == 2); quiet_out = (ph == 2);
      load_params(ph == 3);
      for (int n = 0; n < 350; n++) begin
        case ($urandom_range(19))
          0: t = mk(mfcs_pkg::CMD_LOAD_PARAM, 8'($urandom_range(40)), rnd_small());
          1: t = mk(mfcs_pkg::CMD_LOAD_SIG, 8'($urandom), $urandom);
          2, 3: t = mk(mfcs_pkg::CMD_FINISH, 8'($urandom), $urandom);
          4: t = mk(mfcs_pkg::CMD_CLEAR, 8'($urandom), $urandom);
          5: t = mk(3'($urandom_range(7, 5)), 8'($urandom), $urandom);
          default: t = mk_eval($urandom_range(1) ? $urandom : rnd_small(),
                               $urandom_range(1) ? $urandom : rnd_small(),
                               $urandom_range(1) ? $urandom : rnd_small(),
                               17'($urandom_range(9) == 0 ? $urandom
                                                          : $urandom_range(65536)));
        endcase
        pending_cmds.push_back(t);
      end
      pending_cmds.push_back(mk(mfcs_pkg::CMD_FINISH, 8'd0, 32'd0));
      drain();
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
